// ===== hw/rtl/extended_twin_reduction_check_top_assert.svh =====
// Assertion macros used by the query engine of the extended twin reduction check RTL.
`ifndef EXTENDED_TWIN_REDUCTION_CHECK_TOP_ASSERT_SVH
`define EXTENDED_TWIN_REDUCTION_CHECK_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define ETR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ETR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/etr_pkg.sv =====
// Shared constants, codes and types of the extended twin reduction check.
package etr_pkg;

    localparam int unsigned MAX_VERTICES = 4096;
    localparam int unsigned MAX_EDGES    = 65536;

    localparam int unsigned VW    = $clog2(MAX_VERTICES);   // vertex number width
    localparam int unsigned OAW   = $clog2(MAX_VERTICES + 1); // offset table address width
    localparam int unsigned EAW   = $clog2(MAX_EDGES);       // edge slot width
    localparam int unsigned DEGW  = EAW + 1;                 // degree and offset width
    localparam int unsigned CANDW = VW + 1;                  // candidate count width
    localparam int unsigned WW    = 32;                      // weight width
    localparam int unsigned SUMW  = 44;                      // neighbourhood sum width
    localparam int unsigned CFGW  = 13;                      // vertex_count width
    localparam int unsigned IDXW  = 16;
    localparam int unsigned VALW  = 17;

    localparam logic [CFGW-1:0] VCOUNT_RESET = CFGW'(MAX_VERTICES);

    typedef enum logic [2:0] {
        MODE_OFFSET = 3'd0,
        MODE_EDGE   = 3'd1,
        MODE_WEIGHT = 3'd2,
        MODE_ACTIVE = 3'd3,
        MODE_QUERY  = 3'd4
    } t_mode;

    typedef struct packed {
        logic          found;
        logic [1:0]    rcount;
        logic [VW-1:0] twin;
        logic [VW-1:0] qvert;
    } t_result;

endpackage

// ===== hw/rtl/extended_twin_reduction_check_top.sv =====
// Top level of the extended twin reduction check: ports, configuration and result register.
//
// Usage. Items arrive on the slave stream: tuser carries the mode, tdata the index, value
// and weight. Modes 0 to 3 load the offset table, edge targets, vertex weights and active
// flags, one item a cycle while no query runs, with no result; unknown modes are taken
// and dropped. Mode 4 queries vertex u and gives one result item: found, reduce count,
// twin vertex and u, which reads as zero unless the count is two.
// The configuration channel writes vertex_count, the starting bound on the least degree;
// it is always ready and should be written only while no query is in flight.
// Steps. An out-of-range vertex goes straight to the output state, an inactive one after
// u's flag is read. Otherwise a query reads u's flag and weight, fetches the edge range
// of u, of the least-degree neighbour and of each candidate that passes the weight test,
// walks each of those lists, checking each in-range target, and u's list again to clear
// the marks, reads the offset of each active neighbour of u, weighs each candidate and
// hands the result over. The reads of the memories are registered.
// Throughput. Items are handled one at a time; the next item waits for the query to end.
// Reset. After i_rst_n rises the active flags and marks are swept clear, one vertex a
// cycle, through all 4096 vertices; no item is taken during the sweep.
// Stalls. A result waits in the output register while tready is low; loads and the next
// query are still taken, and that query holds its result until the register frees.
module extended_twin_reduction_check_top import etr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [71:0]      i_s_tdata,   // index[15:0], value[32:16], weight[64:33], zero pad
    input  logic [2:0]       i_s_tuser,   // mode[2:0]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [31:0]      o_m_tdata,   // found[0], reduce_count[2:1], twin_vertex[14:3],
                                          // query_vertex[26:15], zero pad
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFGW-1:0]  i_cfg_data
);

    logic [CFGW-1:0] r_vcount;
    logic            r_ovalid;
    t_result         r_out;
    t_result         eng_res;
    logic            eng_valid;
    logic            eng_ready;

    assign o_cfg_ready = 1'b1;

    // The result register is free when empty or being drained this cycle.
    assign eng_ready = !r_ovalid || i_m_tready;

    etr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vcount    (r_vcount),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_mode      (i_s_tuser),
        .i_index     (i_s_tdata[15:0]),
        .i_value     (i_s_tdata[32:16]),
        .i_weight    (i_s_tdata[64:33]),
        .o_res_valid (eng_valid),
        .i_res_ready (eng_ready),
        .o_res       (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
            if (eng_ready) begin
                r_ovalid <= eng_valid;
            end
        end
        if (eng_ready && eng_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_out.qvert, r_out.twin, r_out.rcount, r_out.found};

endmodule

// ===== hw/rtl/etr_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module etr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/etr_engine.sv =====
// Graph memories and the query sequencer that walks them.
module etr_engine import etr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFGW-1:0]  i_vcount,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0]       i_mode,
    input  logic [IDXW-1:0]  i_index,
    input  logic [VALW-1:0]  i_value,
    input  logic [WW-1:0]    i_weight,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_Q1, S_RA, S_RB, S_RC, S_CHK, S_TGT,
        S_AV, S_AD, S_BV, S_CK, S_CT, S_CW, S_CY, S_OUT
    } t_state;

    typedef enum logic [1:0] {P_A, P_B, P_C, P_D} t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [VW-1:0]     r_clr, n_clr;
    logic [VW-1:0]     r_u, n_u;
    logic [VW-1:0]     r_v, n_v;
    logic [VW-1:0]     r_t, n_t;
    logic [VW-1:0]     r_ldv, n_ldv;
    logic [DEGW-1:0]   r_rs, n_rs;
    logic [DEGW-1:0]   r_i, n_i;
    logic [DEGW-1:0]   r_re, n_re;
    logic [DEGW-1:0]   r_us, n_us;
    logic [DEGW-1:0]   r_ue, n_ue;
    logic [DEGW-1:0]   r_ts, n_ts;
    logic [DEGW-1:0]   r_min, n_min;
    logic              r_have, n_have;
    logic [DEGW-1:0]   r_deg, n_deg;
    logic [DEGW-1:0]   r_cnt, n_cnt;
    logic [SUMW-1:0]   r_sum, n_sum;
    logic [WW-1:0]     r_wu, n_wu;
    logic [CANDW-1:0]  r_ncand, n_ncand;
    logic [CANDW-1:0]  r_k, n_k;
    t_result           r_res, n_res;

    // memory ports
    logic              off_we,  edg_we,  wgt_we,  act_we,  mrk_we,  cnd_we;
    logic [OAW-1:0]    off_wa,  off_ra;
    logic [DEGW-1:0]   off_wd,  off_rd;
    logic [EAW-1:0]    edg_wa,  edg_ra;
    logic [VW:0]       edg_wd,  edg_rd;
    logic [VW-1:0]     wgt_wa,  wgt_ra;
    logic [WW-1:0]     wgt_wd,  wgt_rd;
    logic [VW-1:0]     act_wa,  act_ra,  mrk_wa,  mrk_ra,  cnd_wa,  cnd_ra;
    logic              act_wd,  act_rd,  mrk_wd,  mrk_rd;
    logic [VW-1:0]     cnd_wd,  cnd_rd;

    logic              accept;
    logic              idx_vert, idx_off;
    logic              e_oor;
    logic [VW-1:0]     e_t;
    logic [DEGW-1:0]   rng_end, deg_t, cnt_n;
    logic [SUMW:0]     sum_x;
    logic [SUMW:0]     pair_w;

    etr_ram #(.WIDTH(DEGW), .DEPTH(MAX_VERTICES + 1)) u_off (
        .i_clk(i_clk), .i_we(off_we), .i_waddr(off_wa), .i_wdata(off_wd),
        .i_raddr(off_ra), .o_rdata(off_rd));
    etr_ram #(.WIDTH(VW + 1), .DEPTH(MAX_EDGES)) u_edge (
        .i_clk(i_clk), .i_we(edg_we), .i_waddr(edg_wa), .i_wdata(edg_wd),
        .i_raddr(edg_ra), .o_rdata(edg_rd));
    etr_ram #(.WIDTH(WW), .DEPTH(MAX_VERTICES)) u_wgt (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(wgt_wa), .i_wdata(wgt_wd),
        .i_raddr(wgt_ra), .o_rdata(wgt_rd));
    etr_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_act (
        .i_clk(i_clk), .i_we(act_we), .i_waddr(act_wa), .i_wdata(act_wd),
        .i_raddr(act_ra), .o_rdata(act_rd));
    etr_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_mark (
        .i_clk(i_clk), .i_we(mrk_we), .i_waddr(mrk_wa), .i_wdata(mrk_wd),
        .i_raddr(mrk_ra), .o_rdata(mrk_rd));
    etr_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_cand (
        .i_clk(i_clk), .i_we(cnd_we), .i_waddr(cnd_wa), .i_wdata(cnd_wd),
        .i_raddr(cnd_ra), .o_rdata(cnd_rd));

    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    assign idx_vert = (32'(i_index) < MAX_VERTICES);
    assign idx_off  = (32'(i_index) <= MAX_VERTICES);

    // An edge entry carries an out-of-range flag above the vertex number.
    assign e_oor = edg_rd[VW];
    assign e_t   = edg_rd[VW-1:0];

    assign rng_end = (off_rd > r_rs) ? off_rd : r_rs;
    assign deg_t   = ((off_rd > r_ts) ? off_rd : r_ts) - r_ts;
    assign cnt_n   = r_cnt + DEGW'(1);
    assign sum_x   = {1'b0, r_sum} + (SUMW + 1)'(wgt_rd);
    assign pair_w  = (SUMW + 1)'(wgt_rd) + (SUMW + 1)'(r_wu);

    // Memory addressing and writes
    always_comb begin
        off_we = 1'b0;  off_wa = i_index[OAW-1:0];  off_wd = i_value;
        edg_we = 1'b0;  edg_wa = i_index[EAW-1:0];
        edg_wd = {(|i_value[VALW-1:VW]), i_value[VW-1:0]};
        wgt_we = 1'b0;  wgt_wa = i_index[VW-1:0];   wgt_wd = i_weight;
        act_we = 1'b0;  act_wa = i_index[VW-1:0];   act_wd = i_value[0];
        mrk_we = 1'b0;  mrk_wa = r_t;               mrk_wd = 1'b0;
        cnd_we = 1'b0;  cnd_wa = r_ncand[VW-1:0];   cnd_wd = e_t;

        off_ra = {1'b0, r_v};
        edg_ra = r_i[EAW-1:0];
        wgt_ra = e_t;
        act_ra = e_t;
        mrk_ra = e_t;
        cnd_ra = r_k[VW-1:0];

        case (r_state)
            S_CLR: begin
                act_we = 1'b1;  act_wa = r_clr;  act_wd = 1'b0;
                mrk_we = 1'b1;  mrk_wa = r_clr;  mrk_wd = 1'b0;
            end
            S_IDLE: begin
                wgt_ra = i_index[VW-1:0];
                act_ra = i_index[VW-1:0];
                if (accept) begin
                    case (i_mode)
                        MODE_OFFSET: off_we = idx_off;
                        MODE_EDGE:   edg_we = 1'b1;
                        MODE_WEIGHT: wgt_we = idx_vert;
                        MODE_ACTIVE: act_we = idx_vert;
                        default: ;
                    endcase
                end
            end
            S_RB:  off_ra = OAW'(r_v) + OAW'(1);
            S_TGT: begin
                off_ra = {1'b0, e_t};
                if (r_phase == P_D && !e_oor) begin
                    mrk_we = 1'b1;  mrk_wa = e_t;  mrk_wd = 1'b0;
                end
            end
            S_AV: begin
                off_ra = OAW'(r_t) + OAW'(1);
                if (act_rd) begin
                    mrk_we = 1'b1;  mrk_wa = r_t;  mrk_wd = 1'b1;
                end
            end
            S_BV: begin
                cnd_wd = r_t;
                cnd_we = act_rd && (r_t != r_u) && !mrk_rd
                         && (32'(r_ncand) < MAX_VERTICES);
            end
            S_CT: wgt_ra = cnd_rd;
            default: ;
        endcase
    end

    // Query sequencer
    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_clr = r_clr;
        n_u = r_u;  n_v = r_v;  n_t = r_t;  n_ldv = r_ldv;
        n_rs = r_rs;  n_i = r_i;  n_re = r_re;  n_us = r_us;  n_ue = r_ue;
        n_ts = r_ts;  n_min = r_min;  n_have = r_have;  n_deg = r_deg;
        n_cnt = r_cnt;  n_sum = r_sum;  n_wu = r_wu;  n_ncand = r_ncand;
        n_k = r_k;  n_res = r_res;

        case (r_state)
            S_CLR: begin
                n_clr = r_clr + VW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_mode == MODE_QUERY) begin
                    n_u   = i_index[VW-1:0];
                    n_res = '0;
                    n_state = idx_vert ? S_Q1 : S_OUT;
                end
            end
            S_Q1: begin
                if (!act_rd) begin
                    n_state = S_OUT;
                end else begin
                    n_wu = wgt_rd;  n_sum = '0;  n_deg = '0;  n_have = 1'b0;
                    n_min = DEGW'(i_vcount);  n_ncand = '0;
                    n_v = r_u;  n_phase = P_A;  n_state = S_RA;
                end
            end
            S_RA: n_state = S_RB;
            S_RB: begin
                n_rs = off_rd;
                n_state = S_RC;
            end
            S_RC: begin
                n_i = r_rs;  n_re = rng_end;
                if (r_phase == P_A) begin
                    n_us = r_rs;  n_ue = rng_end;
                end
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_i < r_re) begin
                    n_state = S_TGT;
                end else begin
                    case (r_phase)
                        P_A: begin
                            if (r_have) begin
                                n_v = r_ldv;  n_phase = P_B;  n_state = S_RA;
                            end else begin
                                n_i = r_us;  n_re = r_ue;  n_phase = P_D;
                            end
                        end
                        P_B: begin
                            n_k = '0;  n_state = S_CK;
                        end
                        P_C: begin
                            // every active neighbour of the candidate lies in N(u)
                            n_res.found  = 1'b1;
                            n_res.twin   = r_t;
                            n_res.rcount = (r_cnt == r_deg) ? 2'd2 : 2'd1;
                            n_res.qvert  = (r_cnt == r_deg) ? r_u : '0;
                            n_i = r_us;  n_re = r_ue;  n_phase = P_D;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_TGT: begin
                n_t = e_t;
                n_i = r_i + DEGW'(1);
                n_state = S_CHK;
                if (!e_oor) begin
                    case (r_phase)
                        P_A: n_state = S_AV;
                        P_B: n_state = S_BV;
                        P_C: n_state = S_CY;
                        default: ;
                    endcase
                end
                if (r_phase == P_C) begin
                    n_t = r_t;
                end
            end
            S_AV: begin
                if (act_rd) begin
                    n_sum = sum_x[SUMW] ? '1 : sum_x[SUMW-1:0];
                    n_deg = r_deg + DEGW'(1);
                    n_ts  = off_rd;
                    n_state = S_AD;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_AD: begin
                if (deg_t < r_min) begin
                    n_min = deg_t;  n_ldv = r_t;  n_have = 1'b1;
                end
                n_state = S_CHK;
            end
            S_BV: begin
                if (act_rd && (r_t != r_u) && !mrk_rd && (32'(r_ncand) < MAX_VERTICES)) begin
                    n_ncand = r_ncand + CANDW'(1);
                end
                n_state = S_CHK;
            end
            S_CK: begin
                if (r_k < r_ncand) begin
                    n_state = S_CT;
                end else begin
                    n_i = r_us;  n_re = r_ue;  n_phase = P_D;  n_state = S_CHK;
                end
            end
            S_CT: begin
                n_t = cnd_rd;
                n_state = S_CW;
            end
            S_CW: begin
                if (pair_w < {1'b0, r_sum}) begin
                    n_k = r_k + CANDW'(1);
                    n_state = S_CK;
                end else begin
                    n_v = r_t;  n_cnt = '0;  n_phase = P_C;  n_state = S_RA;
                end
            end
            S_CY: begin
                n_state = S_CHK;
                if (act_rd) begin
                    if (!mrk_rd || cnt_n > r_deg) begin
                        n_k = r_k + CANDW'(1);
                        n_state = S_CK;
                    end else begin
                        n_cnt = cnt_n;
                    end
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_phase <= P_A;
            r_clr   <= '0;
            r_ncand <= '0;
            r_k     <= '0;
            r_have  <= 1'b0;
            r_sum   <= '0;
            r_deg   <= '0;
            r_ldv   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_clr   <= n_clr;
            r_ncand <= n_ncand;
            r_k     <= n_k;
            r_have  <= n_have;
            r_sum   <= n_sum;
            r_deg   <= n_deg;
            r_ldv   <= n_ldv;
        end
        r_u   <= n_u;    r_v   <= n_v;    r_t   <= n_t;
        r_rs  <= n_rs;   r_i   <= n_i;    r_re  <= n_re;
        r_us  <= n_us;   r_ue  <= n_ue;   r_ts  <= n_ts;
        r_min <= n_min;  r_cnt <= n_cnt;  r_wu  <= n_wu;
        r_res <= n_res;
    end

`include "extended_twin_reduction_check_top_assert.svh"

    `ETR_ASSERT_IMP(a_ncand_bound, 1'b1, 32'(r_ncand) <= MAX_VERTICES, "candidate count overflow")
    `ETR_ASSERT_IMP(a_found_count, o_res_valid && o_res.found,
        o_res.rcount == 2'd1 || o_res.rcount == 2'd2, "found result with bad count")
    `ETR_ASSERT_IMP(a_miss_zero, o_res_valid && !o_res.found,
        o_res.rcount == 2'd0 && o_res.twin == '0 && o_res.qvert == '0, "miss not zeroed")
    `ETR_ASSERT_NXT(a_load_stays_idle, accept && i_mode != MODE_QUERY,
        r_state == S_IDLE, "load item left the idle state")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the extended twin reduction check block.
//
// What is tested: the block is loaded with small graphs in compressed-row form and then
// queried. A scoreboard object keeps its own copy of the offset table, the edge targets,
// the weights, the active flags and vertex_count. For every accepted query it works out
// the expected result: the marking of u's active neighbours, the neighbour of least
// degree, the candidate walk and the twin test. Each result item taken from the block is
// compared field by field with the oldest prediction.
//
// How: a short directed part first drives unknown modes, loads with out-of-range indexes
// and queries of out-of-range and inactive vertices. It then runs several phases. Each
// phase sets vertex_count, clears the active flags, loads a fresh random graph of at most
// twelve vertices and sends a mix of queries and in-range noise. Twin pairs are planted
// in every graph so that positive results occur. One graph is placed at the top of the
// edge table so that the edge walk wraps round. Offsets are rewritten at random inside
// the loaded edge range, which gives decreasing offsets and empty ranges. Only entries
// that were written are ever read by a query. Both stream sides idle at random, apart
// from one phase that runs with no idling at all.
module testbench;
    import etr_pkg::*;

    // Scoreboard: predicts the results of queries and checks the block's results.
    class twin_scoreboard;
        bit [16:0] offsets [0:4096];
        bit [16:0] targets [0:65535];
        bit [31:0] weights [0:4095];
        bit        active  [0:4095];
        bit [12:0] vcount;
        t_result   pending [$];
        int        errors;
        int        queries;
        int        twins;

        function new();
            vcount = VCOUNT_RESET;
            foreach (active[i]) active[i] = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function int unsigned range_end(int unsigned v);
            int unsigned s;
            int unsigned e;
            s = 32'(offsets[v]);
            e = 32'(offsets[v+1]);
            return (e > s) ? e : s;
        endfunction

        function bit live(int unsigned v);
            return v < MAX_VERTICES && active[v];
        endfunction

        // Works out the reduction result for query vertex u.
        function t_result twin_search(int unsigned u);
            t_result r;
            bit          mark [int];
            int unsigned cand [$];
            longint unsigned nsum;
            int unsigned deg_u;
            int unsigned min_deg;
            int unsigned least;
            int unsigned t;
            int unsigned x;
            int unsigned d;
            int unsigned cnt;
            bit have_min;
            bit ok;
            r = '0;
            if (!live(u)) return r;
            nsum = 0;
            deg_u = 0;
            min_deg = 32'(vcount);
            have_min = 0;
            least = 0;
            for (int unsigned i = offsets[u]; i < range_end(u); i++) begin
                t = 32'(targets[i % MAX_EDGES]);
                if (!live(t)) continue;
                mark[t] = 1;
                nsum += 64'(weights[t]);
                if (nsum > 44'hFFF_FFFF_FFFF) nsum = 44'hFFF_FFFF_FFFF;
                deg_u++;
                d = range_end(t) - 32'(offsets[t]);
                if (d < min_deg) begin
                    min_deg = d;
                    least = t;
                    have_min = 1;
                end
            end
            if (!have_min) return r;
            for (int unsigned i = offsets[least]; i < range_end(least); i++) begin
                t = 32'(targets[i % MAX_EDGES]);
                if (live(t) && t != u && !mark.exists(t) && cand.size() < MAX_VERTICES)
                    cand.push_back(t);
            end
            foreach (cand[k]) begin
                t = cand[k];
                if (longint'(weights[t]) + longint'(weights[u]) < nsum) continue;
                cnt = 0;
                ok = 1;
                for (int unsigned j = offsets[t]; j < range_end(t); j++) begin
                    x = 32'(targets[j % MAX_EDGES]);
                    if (!live(x)) continue;
                    cnt++;
                    if (!mark.exists(x) || cnt > deg_u) begin
                        ok = 0;
                        break;
                    end
                end
                if (!ok) continue;
                r.found  = 1;
                r.rcount = (cnt == deg_u) ? 2'd2 : 2'd1;
                r.twin   = t[VW-1:0];
                r.qvert  = (cnt == deg_u) ? u[VW-1:0] : '0;
                return r;
            end
            return r;
        endfunction

        // Notes an item accepted by the block: loads update the copy, queries predict.
        function void note_item(bit [2:0] mode, bit [15:0] idx, bit [16:0] val,
                                bit [31:0] w);
            case (mode)
                MODE_OFFSET: if (idx <= MAX_VERTICES) offsets[idx] = val;
                MODE_EDGE:   targets[idx] = val;
                MODE_WEIGHT: if (idx < MAX_VERTICES) weights[idx] = w;
                MODE_ACTIVE: if (idx < MAX_VERTICES) active[idx] = val[0];
                MODE_QUERY: begin
                    pending.push_back(twin_search(32'(idx)));
                    queries++;
                end
                default: ;
            endcase
        endfunction

        task check_result(bit [31:0] data);
            t_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result item %h", data));
                return;
            end
            e = pending.pop_front();
            if (e.found) twins++;
            if (data[0] !== e.found)
                report($sformatf("found %0d, expected %0d", data[0], e.found));
            if (data[2:1] !== e.rcount)
                report($sformatf("reduce_count %0d, expected %0d", data[2:1], e.rcount));
            if (data[14:3] !== e.twin)
                report($sformatf("twin_vertex %0d, expected %0d", data[14:3], e.twin));
            if (data[26:15] !== e.qvert)
                report($sformatf("query_vertex %0d, expected %0d", data[26:15], e.qvert));
            if (data[31:27] !== 5'd0)
                report($sformatf("padding bits %h not zero", data[31:27]));
        endtask
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_tvalid;
    logic            o_s_tready;
    logic [71:0]     i_s_tdata;
    logic [2:0]      i_s_tuser;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [31:0]     o_m_tdata;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [CFGW-1:0] i_cfg_data;

    twin_scoreboard sb;
    bit             quiet;      // set for the stretch with no idling on either side
    int             load_items;

    extended_twin_reduction_check_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // index[15:0], value[32:16], weight[64:33], zero pad
        .i_s_tuser  (i_s_tuser),   // mode[2:0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // found[0], reduce_count[2:1], twin_vertex[14:3],
                                   // query_vertex[26:15], zero pad
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls at random, about 11 percent of the time, except in the quiet stretch.
    always @(negedge i_clk)
        i_m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);

    // Results are sampled at the rising edge, before the block's registers move on.
    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);

    // Sends one item; valid stays high across back-to-back items, so the next call
    // overwrites the data at the following falling edge without lowering valid.
    task send_item(bit [2:0] mode, bit [15:0] idx, bit [16:0] val, bit [31:0] w);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {7'd0, w, val, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_item(mode, idx, val, w);
        if (mode != MODE_QUERY) load_items++;
        // Random gaps between items land on every phase of the block's work.
        if (!quiet && $urandom_range(99) < 11) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task drop_valid();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // Waits until every predicted result has come, then lets the block settle.
    task drain();
        drop_valid();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task write_vcount(bit [12:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.vcount = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads a random graph of nv vertices whose edges start at slot base, then queries it.
    task run_graph(int nv, int unsigned base, int nq);
        bit [15:0] adj [16];
        int unsigned slot;
        int u;
        int t;
        int r;
        for (int v = 0; v < 16; v++) send_item(MODE_ACTIVE, 16'(v), 17'd0, 32'd0);
        for (int v = 0; v < 16; v++) adj[v] = '0;
        for (int a = 0; a < nv; a++)
            for (int b = a + 1; b < nv; b++)
                if ($urandom_range(99) < 40) begin
                    adj[a][b] = 1;
                    adj[b][a] = 1;
                end
        // Plant a twin pair: t copies u's neighbourhood and stays apart from u.
        u = $urandom_range(nv - 1);
        t = (u + 1 + $urandom_range(nv - 2)) % nv;
        adj[u][t] = 0;
        adj[t][u] = 0;
        for (int v = 0; v < nv; v++)
            if (v != u && v != t) begin
                adj[t][v] = adj[u][v];
                adj[v][t] = adj[u][v];
            end
        slot = base;
        for (int v = 0; v < nv; v++) begin
            send_item(MODE_OFFSET, 16'(v), 17'(slot), $urandom);
            for (int b = 0; b < nv; b++)
                if (adj[v][b]) begin
                    send_item(MODE_EDGE, 16'(slot % MAX_EDGES), 17'(b), $urandom);
                    slot++;
                end
            // An occasional target beyond the vertex range counts as inactive.
            if ($urandom_range(99) < 20) begin
                send_item(MODE_EDGE, 16'(slot % MAX_EDGES),
                          17'($urandom_range(4096, 65536)), 32'd0);
                slot++;
            end
        end
        send_item(MODE_OFFSET, 16'(nv), 17'(slot), 32'd0);
        for (int v = 0; v < nv; v++) begin
            r = $urandom_range(99);
            send_item(MODE_WEIGHT, 16'(v), 17'($urandom),
                      r < 5 ? 32'hFFFF_FFFF : r < 10 ? 32'd0 : $urandom_range(1, 20));
            send_item(MODE_ACTIVE, 16'(v),
                      {16'($urandom_range(65535)), ($urandom_range(99) < 90) ? 1'b1 : 1'b0},
                      32'd0);
        end
        for (int q = 0; q < nq; q++) begin
            r = $urandom_range(99);
            if (r < 80)
                send_item(MODE_QUERY, 16'($urandom_range(nv + 1)), 17'($urandom), $urandom);
            else if (r < 90)
                // Offsets rewritten inside the loaded range: empty and shifted ranges.
                send_item(MODE_OFFSET, 16'($urandom_range(nv)),
                          17'($urandom_range(base, slot)), 32'd0);
            else if (r < 95)
                send_item(MODE_WEIGHT, 16'($urandom_range(nv - 1)), 17'd0,
                          $urandom_range(1) ? $urandom : $urandom_range(0, 30));
            else
                send_item(MODE_ACTIVE, 16'($urandom_range(nv - 1)),
                          17'($urandom_range(1)), 32'd0);
        end
        drain();
    endtask

    initial begin
        int unsigned base;
        sb = new();
        quiet       = 1'b0;
        load_items  = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: unknown modes, ignored loads and queries that cannot succeed.
        send_item(3'd5, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF);
        send_item(3'd7, 16'h0000, 17'h00000, 32'h0000_0000);
        send_item(3'd6, 16'h1234, 17'h0ABCD, 32'h5555_AAAA);
        send_item(MODE_OFFSET, 16'd4097, 17'h1FFFF, 32'd0);
        send_item(MODE_OFFSET, 16'hFFFF, 17'h1FFFF, 32'd0);
        send_item(MODE_OFFSET, 16'd4096, 17'h1FFFF, 32'd0);
        send_item(MODE_WEIGHT, 16'd4096, 17'd0, 32'hFFFF_FFFF);
        send_item(MODE_WEIGHT, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF);
        send_item(MODE_ACTIVE, 16'd4096, 17'h1FFFF, 32'd0);
        send_item(MODE_ACTIVE, 16'hFFFF, 17'd1, 32'd0);
        send_item(MODE_QUERY, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF);
        send_item(MODE_QUERY, 16'd4096, 17'd0, 32'd0);
        send_item(MODE_QUERY, 16'd4095, 17'd0, 32'd0);
        send_item(MODE_QUERY, 16'd0, 17'd0, 32'd0);
        // An active vertex with an empty range has no neighbour at all.
        send_item(MODE_OFFSET, 16'd0, 17'd10, 32'd0);
        send_item(MODE_OFFSET, 16'd1, 17'd10, 32'd0);
        send_item(MODE_ACTIVE, 16'd0, 17'd1, 32'd0);
        send_item(MODE_QUERY, 16'd0, 17'd0, 32'd0);
        drain();

        // Random phases, each with its own vertex_count; the extremes come first.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_vcount(13'd4096);
                1: write_vcount(13'd1);
                2: write_vcount(13'd2);
                7: write_vcount(13'd4096);
                default: write_vcount(13'($urandom_range(1, 4096)));
            endcase
            quiet = (ph == 4);
            base  = (ph == 3) ? 65530 : $urandom_range(0, 400);
            run_graph($urandom_range(3, 12), base, 30);
        end
        quiet = 1'b0;

        $display("Covered %0d queries (%0d twins found) and %0d load or ignored items,",
                 sb.queries, sb.twins, load_items);
        $display("over eight graphs and vertex_count settings from 1 to 4096.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("extended_twin_reduction_check_top verification clean");
        end else begin
            $display("extended_twin_reduction_check_top verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("extended_twin_reduction_check_top verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/etr_pkg.sv
hw/rtl/etr_ram.sv
hw/rtl/etr_engine.sv
hw/rtl/extended_twin_reduction_check_top.sv
verif/testbench.sv
